// ===== rtl/htfd_pkg.sv =====
// Package for the humidity/temperature frame decoder.
// Holds shared constants, status codes and the CRC unit status struct.
// No dependencies.
package htfd_pkg;

    // CRC-8 of the sensor: MSB first, no reflection, no final XOR
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam int          CRC_BITS    = 16;

    // Frame layout: five held bytes, the sixth completes the frame
    localparam int          HELD_DEPTH  = 5;
    localparam logic [2:0]  FRAME_LAST  = 3'd5;

    // Conversion constants
    localparam logic [15:0] WORD_MAX    = 16'hFFFF;
    localparam logic [15:0] TEMP_SPAN   = 16'd17500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [15:0] HUM_SPAN    = 16'd10000;
    localparam logic [15:0] CENT        = 16'd100;
    // floor(x/100) == (x*RECIP_100) >> 19 for every x below 43699
    localparam logic [15:0] RECIP_100   = 16'd5243;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TEMP_FAIL = 2'd1,
        STATUS_HUM_FAIL  = 2'd2
    } status_t;

    typedef struct packed {
        logic       done;
        logic [7:0] crc;
    } crc_sts_t;

endpackage

// ===== rtl/htfd_in_if.sv =====
// Input channel of the frame decoder: one sensor byte per transaction.
// Depends on nothing.
interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/htfd_out_if.sv =====
// Result channel of the frame decoder: one decoded frame per transaction.
// Depends on nothing.
interface htfd_out_if;
    logic              valid;
    logic              ready;
    logic        [1:0] status;
    logic signed [8:0] temp_whole;
    logic        [6:0] temp_hundredths;
    logic        [6:0] humidity_percent;

    modport source (output valid, output status, output temp_whole,
                    output temp_hundredths, output humidity_percent, input ready);
    modport sink   (input valid, input status, input temp_whole,
                    input temp_hundredths, input humidity_percent, output ready);
endinterface

// ===== rtl/htfd_crc_unit.sv =====
// Bit-serial CRC-8 engine over one 16-bit word, one bit per cycle.
// Depends on htfd_pkg.
module htfd_crc_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [15:0]       data,
    output htfd_pkg::crc_sts_t sts
);

    logic [15:0] shift_reg;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        feedback;

    assign feedback = crc_reg[7] ^ shift_reg[15];
    assign crc_next = {crc_reg[6:0], 1'b0} ^ (feedback ? htfd_pkg::CRC_POLY : 8'h00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(htfd_pkg::CRC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Payload: load on start, advance one bit per busy cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= data;
            crc_reg   <= htfd_pkg::CRC_INIT;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[14:0], 1'b0};
            crc_reg   <= crc_next;
        end
    end

    assign sts.done = done_reg;
    assign sts.crc  = crc_reg;

endmodule

// ===== rtl/humidity_temperature_frame_decode_top.sv =====
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_in_if, htfd_out_if and htfd_crc_unit.
//
// The block takes a sensor frame one byte per input transaction: temperature
// high, low, CRC, humidity high, low, CRC. A transaction with frame_start set
// restarts the frame at byte 0. The first five bytes are held. The sixth
// byte starts the decode and produces one result transaction: the
// temperature CRC-8 (poly 0x31, init 0xFF) is checked bit-serially; on a
// match one shared 16x16 multiplier with a registered product runs the
// scaling word*17500/65535 - 4500 (the division by 65535 folds into one add
// and compare), then splits the result into whole degrees and hundredths
// through a reciprocal multiply by 5243. The humidity CRC is then checked
// bit-serially as well and the multiplier gives word*10000/65535/100. The
// two serial CRC passes take most of the decode time. The input is not ready
// during the decode, nor for a frame-completing byte while an earlier
// result still waits in the output register; the first five bytes of the
// next frame are taken while that result waits.
module humidity_temperature_frame_decode_top (
    input logic         clk,
    input logic         rst_n,
    htfd_in_if.sink     frame,
    htfd_out_if.source  result
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CRC_T = 12'b0000_0000_0010,
        ST_MUL_T = 12'b0000_0000_0100,
        ST_DIV_T = 12'b0000_0000_1000,
        ST_MUL_W = 12'b0000_0001_0000,
        ST_SPLIT = 12'b0000_0010_0000,
        ST_HUND  = 12'b0000_0100_0000,
        ST_CRC_H = 12'b0000_1000_0000,
        ST_MUL_H = 12'b0001_0000_0000,
        ST_DIV_H = 12'b0010_0000_0000,
        ST_MUL_P = 12'b0100_0000_0000,
        ST_HUM   = 12'b1000_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         pos_reg;
    logic [7:0]         held_reg [htfd_pkg::HELD_DEPTH];
    logic [7:0]         hum_ref_reg;
    logic               accept;
    logic [2:0]         pos_eff;
    logic               completes;

    // Shared multiplier and its registered product
    logic [15:0]        mul_a, mul_b;
    logic [31:0]        mul_prod_reg;

    // Fold for division by 65535: p = q0*65535 + (q0 + r0)
    logic [16:0]        fold_sum;
    logic [15:0]        fold_q;

    logic [15:0]        val_reg;
    logic               neg_reg;
    logic [7:0]         w_reg;

    // CRC engine
    logic               crc_start;
    logic [15:0]        crc_data;
    htfd_pkg::crc_sts_t crc_sts;

    // Result register
    logic               out_valid_reg;
    htfd_pkg::status_t  status_reg;
    logic signed [8:0]  temp_whole_reg;
    logic [6:0]         temp_hund_reg;
    logic [6:0]         hum_reg;

    logic               finish;

    // ------------------------------------------------------------------
    // Input side: hold the byte, count the position
    // ------------------------------------------------------------------
    assign frame.ready = (state_reg == ST_IDLE)
                       && !(out_valid_reg && (pos_reg >= htfd_pkg::FRAME_LAST));
    assign accept      = frame.valid && frame.ready;
    assign pos_eff     = frame.frame_start ? 3'd0 : pos_reg;
    assign completes   = (pos_eff >= htfd_pkg::FRAME_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 3'd0;
        else if (accept)
            pos_reg <= completes ? 3'd0 : pos_eff + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !completes)
            held_reg[pos_eff] <= frame.rx_byte;
        if (accept && completes)
            hum_ref_reg <= frame.rx_byte;
    end

    // ------------------------------------------------------------------
    // CRC engine: temperature word on the last byte, humidity word later
    // ------------------------------------------------------------------
    assign crc_start = (accept && completes) || (state_reg == ST_HUND);
    assign crc_data  = (state_reg == ST_HUND) ? {held_reg[3], held_reg[4]}
                                              : {held_reg[0], held_reg[1]};

    htfd_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (crc_start),
        .data  (crc_data),
        .sts   (crc_sts)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: operand select by sequencer step
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = 16'd0;
        mul_b = 16'd0;
        case (state_reg)
            ST_MUL_T:
            begin
                mul_a = {held_reg[0], held_reg[1]};
                mul_b = htfd_pkg::TEMP_SPAN;
            end
            ST_MUL_W:
            begin
                mul_a = val_reg;
                mul_b = htfd_pkg::RECIP_100;
            end
            ST_SPLIT:
            begin
                mul_a = {8'd0, mul_prod_reg[26:19]};
                mul_b = htfd_pkg::CENT;
            end
            ST_MUL_H:
            begin
                mul_a = {held_reg[3], held_reg[4]};
                mul_b = htfd_pkg::HUM_SPAN;
            end
            ST_MUL_P:
            begin
                mul_a = val_reg;
                mul_b = htfd_pkg::RECIP_100;
            end
            default:
            begin
                mul_a = 16'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_prod_reg <= {16'd0, mul_a} * {16'd0, mul_b};
    end

    assign fold_sum = {1'b0, mul_prod_reg[31:16]} + {1'b0, mul_prod_reg[15:0]};
    assign fold_q   = mul_prod_reg[31:16]
                    + {15'd0, (fold_sum >= {1'b0, htfd_pkg::WORD_MAX})};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (accept && completes)
                    state_next = ST_CRC_T;
            ST_CRC_T:
                if (crc_sts.done)
                begin
                    if (crc_sts.crc != held_reg[2])
                    begin
                        state_next = ST_IDLE;
                        finish     = 1'b1;
                    end
                    else
                        state_next = ST_MUL_T;
                end
            ST_MUL_T: state_next = ST_DIV_T;
            ST_DIV_T: state_next = ST_MUL_W;
            ST_MUL_W: state_next = ST_SPLIT;
            ST_SPLIT: state_next = ST_HUND;
            ST_HUND:  state_next = ST_CRC_H;
            ST_CRC_H:
                if (crc_sts.done)
                begin
                    if (crc_sts.crc != hum_ref_reg)
                    begin
                        state_next = ST_IDLE;
                        finish     = 1'b1;
                    end
                    else
                        state_next = ST_MUL_H;
                end
            ST_MUL_H: state_next = ST_DIV_H;
            ST_DIV_H: state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_HUM;
            ST_HUM:
            begin
                state_next = ST_IDLE;
                finish     = 1'b1;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DIV_T:
            begin
                // Temperature in hundredths, kept as sign and magnitude
                neg_reg <= (fold_q < htfd_pkg::TEMP_OFFSET);
                if (fold_q < htfd_pkg::TEMP_OFFSET)
                    val_reg <= htfd_pkg::TEMP_OFFSET - fold_q;
                else
                    val_reg <= fold_q - htfd_pkg::TEMP_OFFSET;
            end
            ST_SPLIT:
                w_reg <= mul_prod_reg[26:19];
            ST_DIV_H:
                val_reg <= fold_q;
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register: free whenever a decode runs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CRC_T:
                if (crc_sts.done && (crc_sts.crc != held_reg[2]))
                begin
                    status_reg     <= htfd_pkg::STATUS_TEMP_FAIL;
                    temp_whole_reg <= 9'sd0;
                    temp_hund_reg  <= 7'd0;
                    hum_reg        <= 7'd0;
                end
            ST_HUND:
            begin
                // Truncate toward zero: negate the magnitude quotient
                temp_whole_reg <= neg_reg ? -$signed({1'b0, w_reg})
                                          : $signed({1'b0, w_reg});
                temp_hund_reg  <= val_reg[6:0] - mul_prod_reg[6:0];
            end
            ST_CRC_H:
                if (crc_sts.done && (crc_sts.crc != hum_ref_reg))
                begin
                    status_reg <= htfd_pkg::STATUS_HUM_FAIL;
                    hum_reg    <= 7'd0;
                end
            ST_HUM:
            begin
                status_reg <= htfd_pkg::STATUS_OK;
                hum_reg    <= mul_prod_reg[25:19];
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = status_reg;
    assign result.temp_whole       = temp_whole_reg;
    assign result.temp_hundredths  = temp_hund_reg;
    assign result.humidity_percent = hum_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= htfd_pkg::FRAME_LAST)
        else $error("byte position beyond frame end");

    a_result_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg != ST_IDLE))
        else $error("result raised without a decode");

    a_crc_done_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        crc_sts.done |-> (state_reg == ST_CRC_T || state_reg == ST_CRC_H))
        else $error("CRC completion outside a check step");

    a_temp_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == htfd_pkg::STATUS_TEMP_FAIL)
        |-> (temp_whole_reg == 9'sd0 && temp_hund_reg == 7'd0 && hum_reg == 7'd0))
        else $error("temperature failure with nonzero fields");

    a_no_decode_over_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_valid_reg || $past(state_reg == ST_IDLE))
        else $error("decode running while a result waits");

endmodule

// ===== tb/sv/tb_humidity_temperature_frame_decode_top.sv =====
// Self-checking testbench for the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_in_if, htfd_out_if and the decoder top level.
// Directed frames first, then random frames, each result checked in order.
module tb_humidity_temperature_frame_decode_top;
    import htfd_pkg::*;

    // Watchdog: longest quiet stretch of a correct run is a send gap, the
    // decode and a result stall; allow far more.
    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEM_TARGET  = 1900;
    localparam int CALM_AFTER   = 1600;   // no idling on either side from here on
    localparam int DRAIN_EVERY  = 500;    // hold the sender until all results are in
    localparam int DRAIN_CYCLES = 64;     // above the worst-case decode
    localparam int ROW_COUNT    = 26;

    // One decoded frame as it leaves the block
    typedef struct {
        status_t           status;
        logic signed [8:0] whole;
        logic        [6:0] hundredths;
        logic        [6:0] humidity;
    } decoded_frame_t;

    // What the sender knows about a byte it puts on the input channel
    typedef struct {
        bit             typed;
        decoded_frame_t frame;
    } byte_note_t;

    // One row of the directed table; the result columns count only when typed
    typedef struct {
        logic [7:0]        value;
        logic              start;
        bit                typed;
        status_t           status;
        logic signed [8:0] whole;
        logic        [6:0] hundredths;
        logic        [6:0] humidity;
    } stim_row_t;

    logic clk;
    logic rst_n;

    htfd_in_if  frame_if ();
    htfd_out_if result_if ();

    humidity_temperature_frame_decode_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_if),
        .result (result_if)
    );

    // Decoder state as the testbench tracks it
    logic [2:0] frame_pos;
    logic [7:0] held_bytes [HELD_DEPTH];

    decoded_frame_t expected_frames [$];
    byte_note_t     pending_notes [$];

    int error_count;
    int sent_count;
    int idle_cycles;
    int gap_odds;
    bit calm;

    byte_note_t untyped_note;

    // Directed frames: coldest/driest, hottest/wettest with no frame start,
    // restart mid-frame into a broken humidity CRC, broken temperature CRC.
    stim_row_t directed_rows [ROW_COUNT] = '{
        '{8'h00, 1'b1, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h81, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h81, 1'b0, 1'b1, STATUS_OK,        -9'sd45, 7'd0, 7'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hAC, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hAC, 1'b0, 1'b1, STATUS_OK,        9'sd130, 7'd0, 7'd100},
        '{8'h55, 1'b1, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h66, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hFF, 1'b1, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hAC, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h00, 1'b0, 1'b1, STATUS_HUM_FAIL,  9'sd130, 7'd0, 7'd0},
        '{8'h00, 1'b1, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h00, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h12, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h34, 1'b0, 1'b0, STATUS_OK,        9'sd0,   7'd0, 7'd0},
        '{8'h56, 1'b0, 1'b1, STATUS_TEMP_FAIL, 9'sd0,   7'd0, 7'd0}
    };

    // Report one mismatch and count it; the run carries on
    task automatic report_fault(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Sensor CRC-8 over a two-byte word, bit-serial, MSB first
    function automatic logic [7:0] sensor_crc8(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0]  acc;
        logic [15:0] bits;
        acc  = CRC_INIT;
        bits = {hi, lo};
        for (int i = 15; i >= 0; i--)
        begin
            if (acc[7] ^ bits[i])
                acc = {acc[6:0], 1'b0} ^ CRC_POLY;
            else
                acc = {acc[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Advance the tracked decoder by one byte; return 1 when a frame completes
    function automatic bit decode_sensor_byte(input logic [7:0] value, input logic start,
                                              output decoded_frame_t res);
        int unsigned pos;
        int unsigned word;
        int          centi;
        int          mag;
        res  = '{STATUS_OK, 9'sd0, 7'd0, 7'd0};
        pos  = start ? 0 : frame_pos;
        if (pos < FRAME_LAST)
        begin
            held_bytes[pos] = value;
            frame_pos       = 3'(pos + 1);
            return 1'b0;
        end
        frame_pos = '0;

        if (sensor_crc8(held_bytes[0], held_bytes[1]) != held_bytes[2])
        begin
            res.status = STATUS_TEMP_FAIL;
            return 1'b1;
        end

        // hundredths of a degree, then split toward zero
        word           = {held_bytes[0], held_bytes[1]};
        centi          = int'((word * TEMP_SPAN) / WORD_MAX) - int'(TEMP_OFFSET);
        mag            = (centi < 0) ? -centi : centi;
        res.whole      = 9'(centi / int'(CENT));
        res.hundredths = 7'(mag % int'(CENT));

        if (sensor_crc8(held_bytes[3], held_bytes[4]) != value)
        begin
            res.status = STATUS_HUM_FAIL;
            return 1'b1;
        end

        word         = {held_bytes[3], held_bytes[4]};
        res.humidity = 7'(((word * HUM_SPAN) / WORD_MAX) / CENT);
        return 1'b1;
    endfunction

    // Random sensor word, biased toward the ends of the scale and below zero degrees
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 16852));
            default: return 16'($urandom);
        endcase
    endfunction

    // Put one byte on the input channel, hold it until accepted, then maybe idle
    task automatic drive_byte(input logic [7:0] value, input logic start,
                              input byte_note_t note);
        pending_notes.push_back(note);
        frame_if.valid       <= 1'b1;
        frame_if.rx_byte     <= value;
        frame_if.frame_start <= start;
        @(posedge clk);
        while (frame_if.ready !== 1'b1)
            @(posedge clk);
        sent_count++;
        if (sent_count >= CALM_AFTER)
            calm = 1'b1;
        if (!calm && $urandom_range(1, 8) <= gap_odds)
        begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // One complete frame with random words; each CRC is mostly right
    task automatic send_frame(input logic start_first);
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic [7:0]  temp_crc;
        logic [7:0]  hum_crc;
        temp_word = pick_word();
        hum_word  = pick_word();
        temp_crc  = sensor_crc8(temp_word[15:8], temp_word[7:0]);
        hum_crc   = sensor_crc8(hum_word[15:8], hum_word[7:0]);
        if ($urandom_range(0, 7) == 0)
            temp_crc = 8'($urandom);
        if ($urandom_range(0, 7) == 0)
            hum_crc = 8'($urandom);
        drive_byte(temp_word[15:8], start_first, untyped_note);
        drive_byte(temp_word[7:0],  1'b0, untyped_note);
        drive_byte(temp_crc,        1'b0, untyped_note);
        drive_byte(hum_word[15:8],  1'b0, untyped_note);
        drive_byte(hum_word[7:0],   1'b0, untyped_note);
        drive_byte(hum_crc,         1'b0, untyped_note);
    endtask

    // Drop valid and hold the sender until every pending result has come out
    task automatic hold_until_drained();
        frame_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: alternate random runs of accepting and stalling, and stay
    // ready once the calm tail of the run begins.
    initial
    begin
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            result_if.ready <= 1'b1;
            repeat ($urandom_range(1, 32)) @(posedge clk);
            if (!calm)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Observe both channels at each edge: feed accepted bytes to the tracked
    // decoder, check each accepted result against the oldest pending frame,
    // and end the run if nothing moves for too long.
    always @(posedge clk)
    begin : observe
        decoded_frame_t predicted;
        decoded_frame_t want;
        byte_note_t     note;
        bit             produced;

        if (frame_if.valid === 1'b1 && frame_if.ready === 1'b1)
        begin
            note     = pending_notes.pop_front();
            produced = decode_sensor_byte(frame_if.rx_byte, frame_if.frame_start, predicted);
            if (produced)
                expected_frames.push_back(note.typed ? note.frame : predicted);
            else if (note.typed)
                report_fault("table row expects a result but the frame is not complete");
        end

        if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (expected_frames.size() == 0)
                report_fault($sformatf("result with no frame pending, status %0d",
                                       result_if.status));
            else
            begin
                want = expected_frames.pop_front();
                if (result_if.status !== want.status)
                    report_fault($sformatf("status expected %0d got %0d",
                                           want.status, result_if.status));
                if (result_if.temp_whole !== want.whole)
                    report_fault($sformatf("temp_whole expected %0d got %0d",
                                           want.whole, result_if.temp_whole));
                if (result_if.temp_hundredths !== want.hundredths)
                    report_fault($sformatf("temp_hundredths expected %0d got %0d",
                                           want.hundredths, result_if.temp_hundredths));
                if (result_if.humidity_percent !== want.humidity)
                    report_fault($sformatf("humidity_percent expected %0d got %0d",
                                           want.humidity, result_if.humidity_percent));
            end
        end

        // Watchdog on cycles with no transaction on either channel
        if (rst_n === 1'b1)
        begin
            if ((frame_if.valid === 1'b1 && frame_if.ready === 1'b1) ||
                (result_if.valid === 1'b1 && result_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus: reset, the directed table, random frames and noise, then drain
    initial
    begin
        byte_note_t note;
        bit         aligned;
        int         next_drain;
        int         burst;

        rst_n                <= 1'b0;
        frame_if.valid       <= 1'b0;
        frame_if.rx_byte     <= 8'h00;
        frame_if.frame_start <= 1'b0;
        frame_pos    = '0;
        error_count  = 0;
        sent_count   = 0;
        idle_cycles  = 0;
        gap_odds     = 2;
        calm         = 1'b0;
        untyped_note = '{1'b0, '{STATUS_OK, 9'sd0, 7'd0, 7'd0}};
        next_drain   = DRAIN_EVERY;

        // Hold reset, then release it once
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; typed rows carry their own expected frame
        foreach (directed_rows[i])
        begin
            note.typed = directed_rows[i].typed;
            note.frame = '{directed_rows[i].status, directed_rows[i].whole,
                           directed_rows[i].hundredths, directed_rows[i].humidity};
            drive_byte(directed_rows[i].value, directed_rows[i].start, note);
        end

        // Random part: mostly well-formed frames, some cut-off frames and loose bytes
        aligned = 1'b1;
        while (sent_count < ITEM_TARGET)
        begin
            gap_odds = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0:
                begin
                    // cut-off frame; the next one must restart with a frame start
                    burst = $urandom_range(1, 5);
                    for (int k = 0; k < burst; k++)
                        drive_byte(8'($urandom), (k == 0), untyped_note);
                    aligned = 1'b0;
                end
                1:
                begin
                    // loose bytes with random frame start marks
                    burst = $urandom_range(1, 8);
                    for (int k = 0; k < burst; k++)
                        drive_byte(8'($urandom), 1'($urandom_range(0, 1)), untyped_note);
                    aligned = 1'b0;
                end
                default:
                begin
                    // after a complete frame the count is back at byte 0 anyway
                    send_frame(aligned ? 1'($urandom_range(0, 1)) : 1'b1);
                    aligned = 1'b1;
                end
            endcase

            if (sent_count >= next_drain)
            begin
                hold_until_drained();
                next_drain += DRAIN_EVERY;
            end
        end

        // Wait for every pending frame, then a margin for stray results
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/htfd_pkg.sv
rtl/htfd_in_if.sv
rtl/htfd_out_if.sv
rtl/htfd_crc_unit.sv
rtl/humidity_temperature_frame_decode_top.sv
tb/sv/tb_humidity_temperature_frame_decode_top.sv
